// ===== sv/lbc_pkg.sv =====
// Package for the byte-budget LRU tile cache: slot types, cell modes and codes.
// Used by lbc_cell and lru_byte_budget_tile_cache; depends on nothing else.
`timescale 1ns / 1ps
package lbc_pkg;

	localparam int DEF_ENTRIES = 64;
	localparam logic [39:0] MAX_BYTES_RST = 40'd268435456;

	// Action codes of an input word.
	localparam logic [2:0] ACT_GET    = 3'd0;
	localparam logic [2:0] ACT_PUT    = 3'd1;
	localparam logic [2:0] ACT_REMOVE = 3'd2;
	localparam logic [2:0] ACT_CLEAR  = 3'd3;
	localparam logic [2:0] ACT_TRIM   = 3'd4;

	// Status codes of a result word.
	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_MISS   = 2'd1;
	localparam logic [1:0] ST_STALE  = 2'd2;
	localparam logic [1:0] ST_REJECT = 2'd3;

	// Payload of one cached tile.
	typedef struct packed {
		logic [63:0] key;
		logic [63:0] rev;
		logic [25:0] size;
		logic [15:0] handle;
	} slot_t;

	// A slot as seen by a neighbor cell.
	typedef struct packed {
		logic  valid;
		slot_t data;
	} entry_t;

	// Broadcast shift command for the cell row.
	typedef enum logic [3:0] {
		M_HOLD = 4'b0001,
		M_DOWN = 4'b0010,
		M_UP   = 4'b0100,
		M_CLR  = 4'b1000
	} cell_mode_t;

endpackage

// ===== sv/lru_byte_budget_tile_cache.sv =====
// Top level of the byte-budget LRU tile cache: command sequencer and cell row.
// Depends on lbc_pkg and lbc_cell.
//
//  channel   signals                                           direction
//  command   start, busy, action, key, revision,               in (busy out)
//            bitmap_handle, tile_bytes, bitmap_valid
//  result    done, status, out_handle, total_bytes,            out
//            entry_count, evicted
//  config    cfg_we, cfg_wdata (max_bytes)                     in
//
// After the accept edge busy stays high through the match, execute and finish steps on a
// get, remove, clear, rejected put or unused action. A trim or a put of an existing
// key adds an evict step that takes the oldest entry out, one per cycle, until the
// budget is met. A new put adds the evict, slot-limit and insert steps; the slot-limit
// eviction adds no step. done is high in the cycle in which busy falls.
// Slots are kept in recency order in the cell row; position 0 is the newest.
// Reset clears all valid bits, the byte total and the count; no clearing pass.
// busy stays high until the result cycle; the receiver cannot stall a result.
`timescale 1ns / 1ps
module lru_byte_budget_tile_cache #(
	parameter int ENTRIES = lbc_pkg::DEF_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic [63:0] key,
	input  logic [63:0] revision,
	input  logic [15:0] bitmap_handle,
	input  logic [25:0] tile_bytes,
	input  logic        bitmap_valid,
	input  logic        cfg_we,
	input  logic [39:0] cfg_wdata,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] out_handle,
	output logic [39:0] total_bytes,
	output logic [6:0]  entry_count,
	output logic [6:0]  evicted
);
	import lbc_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_MATCH  = 7'b0000010,
		S_EXEC   = 7'b0000100,
		S_EVICT  = 7'b0001000,
		S_FULL   = 7'b0010000,
		S_INSERT = 7'b0100000,
		S_FIN    = 7'b1000000
	} state_t;

	state_t        state_q;
	logic [39:0]   max_q;
	logic [2:0]    act_q;
	logic [63:0]   key_q;
	logic [63:0]   rev_q;
	logic [15:0]   handle_q;
	logic [25:0]   bytes_q;
	logic          bvalid_q;
	logic [39:0]   total_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] ev_q;
	logic          add_chk_q;
	logic          lim_one_q;
	logic          new_put_q;
	logic          add_fin_q;
	logic          found_q;
	logic [IW-1:0] hit_idx_q;
	slot_t         hit_data_q;
	logic          done_q;
	logic [1:0]    status_q;
	logic [15:0]   oh_q;

	entry_t        cells [ENTRIES];
	logic [ENTRIES-1:0] hits;
	logic [ENTRIES-1:0] valids;
	logic [ENTRIES-1:0] backs;
	cell_mode_t    mode;
	logic [IW-1:0] pos;
	entry_t        front;
	entry_t        empty_e;
	logic [IW-1:0] hit_idx;
	slot_t         hit_data;
	logic [25:0]   back_size;
	logic          evict_go;
	logic [IW-1:0] back_idx;

	assign empty_e  = '0;
	assign back_idx = IW'(count_q - CW'(1));

	// Row of recency cells, each fed by its neighbors.
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		entry_t lft;
		entry_t rgt;
		if (i == 0) begin : g_first
			assign lft = front;
		end else begin : g_mid
			assign lft = cells[i-1];
		end
		if (i == ENTRIES - 1) begin : g_last
			assign rgt = empty_e;
			assign backs[i] = cells[i].valid;
		end else begin : g_inner
			assign rgt = cells[i+1];
			assign backs[i] = cells[i].valid && !cells[i+1].valid;
		end
		assign valids[i] = cells[i].valid;
		lbc_cell #(.IW(IW), .IDX(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .mode(mode), .pos(pos),
			.cmp_key(key_q), .left(lft), .right(rgt), .cur(cells[i]), .hit(hits[i])
		);
	end

	// Select the matching and the oldest slot from the one-hot vectors.
	always_comb begin
		hit_idx   = '0;
		hit_data  = '0;
		back_size = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hits[i]) begin
				hit_idx  = hit_idx | IW'(i);
				hit_data = hit_data | cells[i].data;
			end
			if (backs[i]) begin
				back_size = back_size | cells[i].data.size;
			end
		end
	end

	// Eviction continues while over budget and entries beyond a replaced tile remain.
	assign evict_go = (({1'b0, total_q} + (add_chk_q ? 41'(bytes_q) : 41'd0))
		> {1'b0, max_q}) && (count_q > CW'(lim_one_q));

	// Row command and the word entering at the front.
	always_comb begin
		mode  = M_HOLD;
		pos   = hit_idx_q;
		front = '{valid: 1'b1, data: '{key: key_q, rev: rev_q, size: bytes_q,
			handle: handle_q}};
		if (act_q == ACT_GET) begin
			front.data = hit_data_q;
		end
		case (state_q)
			S_EXEC: begin
				case (act_q)
					ACT_GET: begin
						if (found_q) begin
							mode = (hit_data_q.rev != rev_q) ? M_UP : M_DOWN;
						end
					end
					ACT_PUT: begin
						if (found_q && bvalid_q && ({14'd0, bytes_q} <= max_q)) begin
							mode = M_DOWN;
						end
					end
					ACT_REMOVE: begin
						if (found_q) begin
							mode = M_UP;
						end
					end
					ACT_CLEAR: mode = M_CLR;
					default: mode = M_HOLD;
				endcase
			end
			S_EVICT: begin
				if (evict_go) begin
					mode = M_UP;
					pos  = back_idx;
				end
			end
			S_FULL: begin
				if (32'(count_q) >= ENTRIES) begin
					mode = M_UP;
					pos  = back_idx;
				end
			end
			S_INSERT: begin
				mode = M_DOWN;
				pos  = IW'(ENTRIES - 1);
			end
			default: mode = M_HOLD;
		endcase
	end

	// Budget register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_BYTES_RST;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	// Command word and match capture.
	always_ff @(posedge clk) begin
		if (start && state_q == S_IDLE) begin
			act_q    <= action;
			key_q    <= key;
			rev_q    <= revision;
			handle_q <= bitmap_handle;
			bytes_q  <= tile_bytes;
			bvalid_q <= bitmap_valid;
		end
		if (state_q == S_MATCH) begin
			found_q    <= |hits;
			hit_idx_q  <= hit_idx;
			hit_data_q <= hit_data;
		end
	end

	// Sequencer, byte total, count and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			total_q   <= '0;
			count_q   <= '0;
			ev_q      <= '0;
			add_chk_q <= 1'b0;
			lim_one_q <= 1'b0;
			new_put_q <= 1'b0;
			add_fin_q <= 1'b0;
			done_q    <= 1'b0;
			status_q  <= ST_DONE;
			oh_q      <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q   <= S_MATCH;
						ev_q      <= '0;
						status_q  <= ST_DONE;
						oh_q      <= '0;
						add_chk_q <= 1'b0;
						lim_one_q <= 1'b0;
						new_put_q <= 1'b0;
						add_fin_q <= 1'b0;
					end
				end
				S_MATCH: state_q <= S_EXEC;
				S_EXEC: begin
					state_q <= S_FIN;
					case (act_q)
						ACT_GET: begin
							if (!found_q) begin
								status_q <= ST_MISS;
							end else if (hit_data_q.rev != rev_q) begin
								status_q <= ST_STALE;
								total_q  <= total_q - 40'(hit_data_q.size);
								count_q  <= count_q - CW'(1);
							end else begin
								oh_q <= hit_data_q.handle;
							end
						end
						ACT_PUT: begin
							if (!bvalid_q || ({14'd0, bytes_q} > max_q)) begin
								status_q <= ST_REJECT;
							end else begin
								state_q   <= S_EVICT;
								add_chk_q <= 1'b1;
								lim_one_q <= found_q;
								new_put_q <= !found_q;
								add_fin_q <= found_q;
								if (found_q) begin
									total_q <= total_q - 40'(hit_data_q.size);
								end
							end
						end
						ACT_REMOVE: begin
							if (!found_q) begin
								status_q <= ST_MISS;
							end else begin
								total_q <= total_q - 40'(hit_data_q.size);
								count_q <= count_q - CW'(1);
							end
						end
						ACT_CLEAR: begin
							total_q <= '0;
							count_q <= '0;
						end
						ACT_TRIM: state_q <= S_EVICT;
						default: state_q <= S_FIN;
					endcase
				end
				S_EVICT: begin
					if (evict_go) begin
						total_q <= total_q - 40'(back_size);
						count_q <= count_q - CW'(1);
						ev_q    <= ev_q + CW'(1);
					end else begin
						state_q <= new_put_q ? S_FULL : S_FIN;
					end
				end
				S_FULL: begin
					state_q <= S_INSERT;
					if (32'(count_q) >= ENTRIES) begin
						total_q <= total_q - 40'(back_size);
						count_q <= count_q - CW'(1);
						ev_q    <= ev_q + CW'(1);
					end
				end
				S_INSERT: begin
					state_q   <= S_FIN;
					count_q   <= count_q + CW'(1);
					add_fin_q <= 1'b1;
				end
				S_FIN: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					if (add_fin_q) begin
						total_q <= total_q + 40'(bytes_q);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result ports; total and count hold still until the next word is taken.
	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign out_handle  = oh_q;
	assign total_bytes = total_q;
	assign entry_count = (32'(count_q) > 32'd127) ? 7'd127 : 7'(count_q);
	assign evicted     = (32'(ev_q) > 32'd127) ? 7'd127 : 7'(ev_q);

	// Keys are unique among valid slots.
	a_hit_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hits))
		else $error("more than one slot matches the key");

	// The count tracks the valid cells.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valids) == 32'(count_q))
		else $error("entry count differs from valid cells");

	// Valid cells form a prefix of the row.
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(backs) == ((count_q == '0) ? 32'd0 : 32'd1))
		else $error("valid cells are not contiguous from the front");

	// A result is strobed only when the sequencer has just finished.
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(state_q) == S_FIN)
		else $error("result strobe outside the finish step");

endmodule

// ===== sv/lbc_cell.sv =====
// One cell of the LRU row: holds the tile at one recency position.
// Depends on lbc_pkg; instantiated in a row by lru_byte_budget_tile_cache.
`timescale 1ns / 1ps
module lbc_cell #(
	parameter int IW  = 6,
	parameter int IDX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lbc_pkg::cell_mode_t mode,
	input  logic [IW-1:0]      pos,
	input  logic [63:0]        cmp_key,
	input  lbc_pkg::entry_t    left,
	input  lbc_pkg::entry_t    right,
	output lbc_pkg::entry_t    cur,
	output logic               hit
);
	import lbc_pkg::*;

	logic  valid_q;
	slot_t data_q;
	logic  take_left;
	logic  take_right;

	// Shift toward the back for cells at or before pos, toward the front at or after it.
	assign take_left  = (mode == M_DOWN) && (IW'(IDX) <= pos);
	assign take_right = (mode == M_UP) && (IW'(IDX) >= pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (mode == M_CLR) begin
			valid_q <= 1'b0;
		end else if (take_left) begin
			valid_q <= left.valid;
		end else if (take_right) begin
			valid_q <= right.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_left) begin
			data_q <= left.data;
		end else if (take_right) begin
			data_q <= right.data;
		end
	end

	assign cur = '{valid: valid_q, data: data_q};
	assign hit = valid_q && (data_q.key == cmp_key);

endmodule

// ===== sim/lru_byte_budget_tile_cache_tb.sv =====
// Self-checking testbench for the byte-budget LRU tile cache top level.
// Depends on lbc_pkg and lru_byte_budget_tile_cache; keeps its own LRU list model.
`timescale 1ns / 1ps
module lru_byte_budget_tile_cache_tb;
	import lbc_pkg::*;

	localparam int SLOTS = DEF_ENTRIES;
	localparam int SETTLE = 120;
	localparam logic [39:0] BUDGET_TOP = 40'hFF_FFFF_FFFF;
	localparam logic [25:0] TILE_TOP = 26'h3FF_FFFF;

	// One command word as queued for the driver.
	typedef struct {
		logic [2:0]  act;
		logic [63:0] tkey;
		logic [63:0] rev;
		logic [15:0] hnd;
		logic [25:0] nbytes;
		logic        bval;
	} tile_req_t;

	// One cached tile in the recency list; index 0 is the newest.
	typedef struct {
		logic [63:0] tkey;
		logic [63:0] rev;
		logic [25:0] nbytes;
		logic [15:0] hnd;
	} tile_t;

	// One expected result word.
	typedef struct {
		logic [1:0]  st;
		logic [15:0] hnd;
		logic [39:0] total;
		logic [6:0]  count;
		logic [6:0]  ev;
	} cache_resp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  action = ACT_GET;
	logic [63:0] key = '0;
	logic [63:0] revision = '0;
	logic [15:0] bitmap_handle = '0;
	logic [25:0] tile_bytes = '0;
	logic        bitmap_valid = 1'b0;
	logic        cfg_we = 1'b0;
	logic [39:0] cfg_wdata = '0;
	logic        done;
	logic [1:0]  status;
	logic [15:0] out_handle;
	logic [39:0] total_bytes;
	logic [6:0]  entry_count;
	logic [6:0]  evicted;

	tile_req_t   pending_words[$];
	cache_resp_t expected_resps[$];
	tile_t       lru_list[$];
	logic [39:0] model_total = '0;
	logic [39:0] model_budget = MAX_BYTES_RST;
	logic [63:0] key_pool[96];
	int          idle_pct = 0;
	int          errors = 0;
	int          words_sent = 0;
	int          resps_seen = 0;
	int          hits_seen = 0;
	int          evictions_seen = 0;
	bit          took = 1'b0;

	lru_byte_budget_tile_cache u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .key(key), .revision(revision),
		.bitmap_handle(bitmap_handle), .tile_bytes(tile_bytes),
		.bitmap_valid(bitmap_valid), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.done(done), .status(status), .out_handle(out_handle),
		.total_bytes(total_bytes), .entry_count(entry_count), .evicted(evicted)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic int find_tile(input logic [63:0] k);
		for (int i = 0; i < lru_list.size(); i++)
			if (lru_list[i].tkey == k)
				return i;
		return -1;
	endfunction

	// Drops the oldest tile and takes its size off the total.
	function automatic void drop_oldest();
		tile_t t;
		t = lru_list.pop_back();
		model_total = model_total - 40'(t.nbytes);
	endfunction

	// Applies one word to the cache model and returns the result it yields.
	function automatic cache_resp_t apply_word(input tile_req_t w);
		cache_resp_t r;
		tile_t t;
		int idx;
		int ev;
		r.st = ST_DONE;
		r.hnd = '0;
		ev = 0;
		idx = find_tile(w.tkey);
		case (w.act)
			ACT_GET: begin
				if (idx < 0) begin
					r.st = ST_MISS;
				end else if (lru_list[idx].rev != w.rev) begin
					model_total = model_total - 40'(lru_list[idx].nbytes);
					lru_list.delete(idx);
					r.st = ST_STALE;
				end else begin
					t = lru_list[idx];
					lru_list.delete(idx);
					lru_list.push_front(t);
					r.hnd = t.hnd;
				end
			end
			ACT_PUT: begin
				t.tkey = w.tkey;
				t.rev = w.rev;
				t.nbytes = w.nbytes;
				t.hnd = w.hnd;
				if (!w.bval || 40'(w.nbytes) > model_budget) begin
					r.st = ST_REJECT;
				end else if (idx >= 0) begin
					// Replacement: only other tiles are evicted to make room.
					model_total = model_total - 40'(lru_list[idx].nbytes);
					lru_list.delete(idx);
					lru_list.push_front(t);
					while (model_total + 40'(w.nbytes) > model_budget && lru_list.size() > 1) begin
						drop_oldest();
						ev++;
					end
					model_total = model_total + 40'(w.nbytes);
				end else begin
					// New tile: evict for bytes, then for a free slot.
					while (model_total + 40'(w.nbytes) > model_budget && lru_list.size() > 0) begin
						drop_oldest();
						ev++;
					end
					if (lru_list.size() >= SLOTS) begin
						drop_oldest();
						ev++;
					end
					lru_list.push_front(t);
					model_total = model_total + 40'(w.nbytes);
				end
			end
			ACT_REMOVE: begin
				if (idx < 0) begin
					r.st = ST_MISS;
				end else begin
					model_total = model_total - 40'(lru_list[idx].nbytes);
					lru_list.delete(idx);
				end
			end
			ACT_CLEAR: begin
				lru_list.delete();
				model_total = '0;
			end
			ACT_TRIM: begin
				while (model_total > model_budget && lru_list.size() > 0) begin
					drop_oldest();
					ev++;
				end
			end
			default: ;
		endcase
		r.total = model_total;
		r.count = 7'(lru_list.size());
		r.ev = 7'(ev);
		return r;
	endfunction

	// Monitor: predicts on each accepted word and checks each result word.
	always @(posedge clk) begin
		tile_req_t w;
		cache_resp_t e;
		took = start && !busy && arst_n;
		if (arst_n && cfg_we)
			model_budget = cfg_wdata;
		if (arst_n && done) begin
			resps_seen++;
			if (status == ST_DONE && out_handle != 0)
				hits_seen++;
			evictions_seen += evicted;
			if (expected_resps.size() == 0) begin
				report("result word with nothing expected");
			end else begin
				e = expected_resps.pop_front();
				if (status !== e.st)
					report($sformatf("status %0d, expected %0d", status, e.st));
				if (out_handle !== e.hnd)
					report($sformatf("out_handle %h, expected %h", out_handle, e.hnd));
				if (total_bytes !== e.total)
					report($sformatf("total_bytes %0d, expected %0d", total_bytes, e.total));
				if (entry_count !== e.count)
					report($sformatf("entry_count %0d, expected %0d", entry_count, e.count));
				if (evicted !== e.ev)
					report($sformatf("evicted %0d, expected %0d", evicted, e.ev));
			end
		end
		if (took) begin
			w.act = action;
			w.tkey = key;
			w.rev = revision;
			w.hnd = bitmap_handle;
			w.nbytes = tile_bytes;
			w.bval = bitmap_valid;
			expected_resps.push_back(apply_word(w));
			words_sent++;
		end
	end

	// Driver: presents queued words at the falling edge, with random gaps.
	always @(negedge clk) begin
		tile_req_t w;
		if (arst_n && (!start || took)) begin
			if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
				w = pending_words.pop_front();
				action <= w.act;
				key <= w.tkey;
				revision <= w.rev;
				bitmap_handle <= w.hnd;
				tile_bytes <= w.nbytes;
				bitmap_valid <= w.bval;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	function automatic tile_req_t mk_word(input logic [2:0] a, input logic [63:0] k,
			input logic [63:0] rv, input logic [15:0] h, input logic [25:0] b,
			input logic bv);
		tile_req_t w;
		w.act = a;
		w.tkey = k;
		w.rev = rv;
		w.hnd = h;
		w.nbytes = b;
		w.bval = bv;
		return w;
	endfunction

	// Random word: keys mostly from a pool larger than the table.
	function automatic tile_req_t rand_word();
		int pick;
		logic [2:0] a;
		logic [63:0] k;
		logic [63:0] rv;
		logic [25:0] b;
		pick = $urandom_range(99);
		if (pick < 36) a = ACT_GET;
		else if (pick < 78) a = ACT_PUT;
		else if (pick < 90) a = ACT_REMOVE;
		else if (pick < 92) a = ACT_CLEAR;
		else if (pick < 97) a = ACT_TRIM;
		else a = 3'(ACT_TRIM + $urandom_range(1, 3));
		if ($urandom_range(99) < 95) k = key_pool[$urandom_range(95)];
		else k = {$urandom, $urandom};
		if ($urandom_range(99) < 94) rv = 64'($urandom_range(1));
		else rv = {$urandom, $urandom};
		pick = $urandom_range(99);
		if (pick < 50) b = 26'($urandom_range(65535));
		else if (pick < 85) b = 26'($urandom_range(4194303));
		else if (pick < 97) b = 26'($urandom) & TILE_TOP;
		else b = $urandom_range(1) ? TILE_TOP : '0;
		return mk_word(a, k, rv, 16'($urandom), b, $urandom_range(99) < 92);
	endfunction

	task automatic drain();
		while (pending_words.size() > 0 || expected_resps.size() > 0 || start)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_budget(input logic [39:0] v);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(input int n, input int idle);
		idle_pct = idle;
		for (int i = 0; i < n; i++)
			pending_words.push_back(rand_word());
		drain();
	endtask

	// Stimulus: directed words, then random phases over several budgets.
	initial begin
		for (int i = 0; i < 96; i++)
			key_pool[i] = {$urandom, $urandom};
		key_pool[0] = '0;
		key_pool[1] = '1;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, every action, each special case.
		pending_words.push_back(mk_word(ACT_GET, '0, '0, '0, '0, 1'b0));
		pending_words.push_back(mk_word(ACT_PUT, '0, '0, 16'hFFFF, TILE_TOP, 1'b1));
		pending_words.push_back(mk_word(ACT_PUT, '1, '1, 16'h1234, 26'd100, 1'b0));
		pending_words.push_back(mk_word(ACT_PUT, '1, '1, 16'hA5A5, 26'd100, 1'b1));
		pending_words.push_back(mk_word(ACT_GET, '0, '0, '0, '0, 1'b0));
		pending_words.push_back(mk_word(ACT_GET, '1, '1, '0, '0, 1'b1));
		pending_words.push_back(mk_word(ACT_PUT, '1, 64'd7, 16'h0001, 26'd300, 1'b1));
		pending_words.push_back(mk_word(ACT_GET, '1, 64'd6, '0, '0, 1'b0));
		pending_words.push_back(mk_word(ACT_GET, '1, 64'd7, '0, '0, 1'b0));
		pending_words.push_back(mk_word(ACT_REMOVE, '0, '0, '0, '0, 1'b0));
		pending_words.push_back(mk_word(ACT_REMOVE, '0, '0, '0, '0, 1'b0));
		pending_words.push_back(mk_word(ACT_PUT, 64'd5, '0, 16'h5555, 26'd20, 1'b1));
		pending_words.push_back(mk_word(ACT_CLEAR, '0, '0, '0, '0, 1'b0));
		pending_words.push_back(mk_word(ACT_TRIM, '0, '0, '0, '0, 1'b0));
		pending_words.push_back(mk_word(3'(ACT_TRIM + 3), '1, '1, '1, TILE_TOP, 1'b1));
		for (int i = 0; i < 5; i++)
			pending_words.push_back(mk_word(ACT_PUT, key_pool[i + 2], '0, 16'(i),
				26'd60000000, 1'b1));
		drain();
		run_random(280, 0);

		// Zero budget: only empty tiles fit, every other tile is rejected.
		write_budget('0);
		pending_words.push_back(mk_word(ACT_PUT, 64'd9, '0, 16'd9, 26'd1, 1'b1));
		pending_words.push_back(mk_word(ACT_PUT, 64'd9, '0, 16'd9, '0, 1'b1));
		run_random(60, 6);

		// Widest budget: the slot limit alone forces evictions.
		write_budget(BUDGET_TOP);
		run_random(320, 62);

		// Tight budget: most new tiles evict for bytes.
		write_budget(40'd20000);
		run_random(240, 0);

		write_budget(MAX_BYTES_RST);
		run_random(280, 6);

		// Lower the budget without trimming, so puts start above the budget.
		write_budget(40'd1000000);
		pending_words.push_back(mk_word(ACT_PUT, 64'd77, '0, 16'd1, 26'd10, 1'b1));
		pending_words.push_back(mk_word(ACT_TRIM, '0, '0, '0, '0, 1'b0));
		run_random(220, 62);

		$display("run covered %0d command words and %0d result words", words_sent, resps_seen);
		$display("get hits %0d, tiles evicted %0d", hits_seen, evictions_seen);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#10_000_000;
		$display("timeout with %0d words pending", pending_words.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
sv/lbc_pkg.sv
sv/lbc_cell.sv
sv/lru_byte_budget_tile_cache.sv
sim/lru_byte_budget_tile_cache_tb.sv
